// ----- design/rvbc_pkg.sv -----
`default_nettype none

package rvbc_pkg;

  localparam int CoordWidth    = 16;
  localparam int CfgWidth      = 14;
  localparam int CfgIndexWidth = 1;
  localparam int ThrWidth      = CfgWidth + 1;
  localparam int SqWidth       = 2 * CoordWidth;
  localparam int RootWidth     = CoordWidth;
  localparam int ProdWidth     = CoordWidth + ThrWidth;
  localparam int NumWidth      = ProdWidth + 1;
  localparam int DenWidth      = ThrWidth + 1;
  localparam int DataWidth     = ((2 * CoordWidth + 7) / 8) * 8;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  localparam logic [CfgIndexWidth-1:0] REG_BODY_RADIUS   = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_DISTANCE = CfgIndexWidth'(1);

  localparam logic [CfgWidth-1:0] BodyRadiusReset   = CfgWidth'(128);
  localparam logic [CfgWidth-1:0] HoldDistanceReset = CfgWidth'(128);

  typedef struct packed {
    logic [CoordWidth-1:0] mag_x;
    logic [CoordWidth-1:0] mag_y;
    logic                  neg_x;
    logic                  neg_y;
    logic                  has_point;
    logic                  last;
  } point_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT,
    ST_TEST,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } back_state_t;

endpackage

`default_nettype wire

// ----- design/rvbc_front.sv -----
`default_nettype none

module rvbc_front
  import rvbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [DataWidth-1:0] s_tdata,   // point_x, point_y
  input  wire logic                 s_tlast,   // last_point
  output point_entry_t              entry,
  output logic                      entry_valid,
  input  wire logic                 pop
);

  point_entry_t               slots [QueueDepth];
  logic [QueuePtrWidth-1:0]   wr_ptr;
  logic [QueuePtrWidth-1:0]   rd_ptr;
  logic [QueueCntWidth-1:0]   count;
  logic [CoordWidth-1:0]      x;
  logic [CoordWidth-1:0]      y;
  point_entry_t               classified;
  logic                       push;

  assign x = s_tdata[CoordWidth-1:0];
  assign y = s_tdata[2*CoordWidth-1:CoordWidth];

  always_comb begin
    classified.neg_x     = x[CoordWidth-1];
    classified.neg_y     = y[CoordWidth-1];
    classified.mag_x     = x[CoordWidth-1] ? (~x + 1'b1) : x;
    classified.mag_y     = y[CoordWidth-1] ? (~y + 1'b1) : y;
    classified.has_point = (x != '0) || (y != '0);
    classified.last      = s_tlast;
  end

  assign s_tready    = (count != QueueCntWidth'(QueueDepth));
  assign push        = s_tvalid && s_tready;
  assign entry_valid = (count != '0);
  assign entry       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rvbc_root.sv -----
`default_nettype none

module rvbc_root
  import rvbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [SqWidth-1:0]   radicand,
  output logic                      done,
  output logic [RootWidth-1:0]      root
);

  localparam int CntWidth = $clog2(RootWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(RootWidth - 1);

  logic                   busy;
  logic [CntWidth-1:0]    step;
  logic [SqWidth-1:0]     rad;
  logic [RootWidth+1:0]   rem;
  logic [RootWidth+1:0]   rem_sh;
  logic [RootWidth+1:0]   trial;
  logic                   fits;

  assign rem_sh = {rem[RootWidth-1:0], rad[SqWidth-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SqWidth-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[RootWidth-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == LastStep);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        busy <= (step != LastStep);
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rvbc_div.sv -----
`default_nettype none

module rvbc_div
  import rvbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NumWidth-1:0]  num,
  input  wire logic [DenWidth-1:0]  den,
  output logic                      done,
  output logic [NumWidth-1:0]       quot
);

  localparam int CntWidth = $clog2(NumWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(NumWidth - 1);

  logic                  busy;
  logic [CntWidth-1:0]   step;
  logic [DenWidth-1:0]   divisor;
  logic [DenWidth-1:0]   rem;
  logic [DenWidth:0]     rem_sh;
  logic                  fits;

  assign rem_sh = {rem, quot[NumWidth-1]};
  assign fits   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= num;
      divisor <= den;
      rem     <= '0;
    end else if (busy) begin
      rem  <= fits ? DenWidth'(rem_sh - {1'b0, divisor}) : DenWidth'(rem_sh);
      quot <= {quot[NumWidth-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == LastStep);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        busy <= (step != LastStep);
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rvbc_back.sv -----
`default_nettype none

module rvbc_back
  import rvbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [ThrWidth-1:0]  threshold,
  input  point_entry_t              entry,
  input  wire logic                 entry_valid,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [DataWidth-1:0]      m_tdata    // vel_x, vel_y
);

  localparam int ExtWidth = RootWidth + ThrWidth;
  localparam logic [NumWidth-1:0] PosLimit =
    NumWidth'((64'd1 << (CoordWidth - 1)) - 64'd1);
  localparam logic [NumWidth-1:0] NegLimit = NumWidth'(64'd1 << (CoordWidth - 1));

  back_state_t                  state;
  back_state_t                  state_next;
  point_entry_t                 cur;
  logic [SqWidth-1:0]           sq_x;
  logic [SqWidth-1:0]           sq_y;
  logic [ThrWidth-1:0]          distance;
  logic [ThrWidth-1:0]          margin;
  logic [ProdWidth-1:0]         prod_x;
  logic [ProdWidth-1:0]         prod_y;
  logic signed [CoordWidth-1:0] box_x_low;
  logic signed [CoordWidth-1:0] box_x_high;
  logic signed [CoordWidth-1:0] box_y_low;
  logic signed [CoordWidth-1:0] box_y_high;
  logic                         any_near;
  logic signed [CoordWidth-1:0] vel_x;
  logic signed [CoordWidth-1:0] vel_y;
  logic signed [CoordWidth-1:0] push_x;
  logic signed [CoordWidth-1:0] push_y;
  logic signed [CoordWidth:0]   sum_x;
  logic signed [CoordWidth:0]   sum_y;
  logic                         root_start;
  logic                         root_done;
  logic [RootWidth-1:0]         root;
  logic                         div_start;
  logic                         div_done_x;
  logic                         div_done_y;
  logic [NumWidth-1:0]          quot_x;
  logic [NumWidth-1:0]          quot_y;
  logic                         near;
  logic                         emit;

  function automatic logic signed [CoordWidth-1:0] push_value(
    input logic [NumWidth-1:0] q,
    input logic                neg
  );
    logic signed [CoordWidth-1:0] r;
    if (neg) begin
      r = (q > PosLimit) ? {1'b0, {(CoordWidth-1){1'b1}}} : $signed(q[CoordWidth-1:0]);
    end else begin
      r = (q > NegLimit) ? {1'b1, {(CoordWidth-1){1'b0}}} : -$signed(q[CoordWidth-1:0]);
    end
    return r;
  endfunction

  rvbc_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq_x + sq_y),
    .done     (root_done),
    .root     (root)
  );

  rvbc_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod_x, 1'b0} + NumWidth'(distance)),
    .den   ({distance, 1'b0}),
    .done  (div_done_x),
    .quot  (quot_x)
  );

  rvbc_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod_y, 1'b0} + NumWidth'(distance)),
    .den   ({distance, 1'b0}),
    .done  (div_done_y),
    .quot  (quot_y)
  );

  assign near   = (ExtWidth'(root) <= ExtWidth'(threshold));
  assign margin = threshold - distance;
  assign push_x = push_value(quot_x, cur.neg_x);
  assign push_y = push_value(quot_y, cur.neg_y);
  assign sum_x  = {box_x_low[CoordWidth-1], box_x_low} + {box_x_high[CoordWidth-1], box_x_high};
  assign sum_y  = {box_y_low[CoordWidth-1], box_y_low} + {box_y_high[CoordWidth-1], box_y_high};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (entry_valid) state_next = ST_SQUARE;
      ST_SQUARE:  state_next = cur.has_point ? ST_ROOT_GO : ST_FINISH;
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT:    if (root_done) state_next = ST_TEST;
      ST_TEST:    state_next = near ? ST_SCALE : ST_FINISH;
      ST_SCALE:   state_next = ST_DIV_GO;
      ST_DIV_GO:  state_next = ST_DIV;
      ST_DIV:     if (div_done_x && div_done_y) state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_FINISH;
      ST_FINISH:  if (!cur.last || !m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE:    pop = entry_valid;
      ST_ROOT_GO: root_start = 1'b1;
      ST_DIV_GO:  div_start = 1'b1;
      ST_FINISH:  emit = cur.last && (!m_tvalid || m_tready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= entry;
    end
    if (state == ST_SQUARE) begin
      sq_x <= SqWidth'(cur.mag_x) * SqWidth'(cur.mag_x);
      sq_y <= SqWidth'(cur.mag_y) * SqWidth'(cur.mag_y);
    end
    if (state == ST_TEST) begin
      distance <= ThrWidth'(root);
    end
    if (state == ST_SCALE) begin
      prod_x <= ProdWidth'(cur.mag_x) * ProdWidth'(margin);
      prod_y <= ProdWidth'(cur.mag_y) * ProdWidth'(margin);
    end
    if (state == ST_UPDATE) begin
      if (!any_near || (push_x < box_x_low))  box_x_low  <= push_x;
      if (!any_near || (push_x > box_x_high)) box_x_high <= push_x;
      if (!any_near || (push_y < box_y_low))  box_y_low  <= push_y;
      if (!any_near || (push_y > box_y_high)) box_y_high <= push_y;
    end
    if (emit) begin
      vel_x <= any_near ? sum_x[CoordWidth:1] : '0;
      vel_y <= any_near ? sum_y[CoordWidth:1] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_near <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        any_near <= 1'b0;
      end else if (state == ST_UPDATE) begin
        any_near <= 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = DataWidth'({vel_y, vel_x});

endmodule

`default_nettype wire

// ----- design/repulsive_vector_box_center_unit.sv -----
// The back end takes a point at the origin from squaring straight to finish, a point
// beyond the threshold through the 16-step square root and the distance test, and a
// near point on through scaling, the 32-step divider that follows the root and the
// box update. m_tvalid is registered when the last point of a scan finishes, which
// waits while an earlier result is still stalled on the output. The back end works on
// one point at a time; a two-entry queue keeps accepting input while it works, until
// full. Reset (rst, synchronous): queue empty, box marked empty, registers back to 128.
`default_nettype none

module repulsive_vector_box_center_unit
  import rvbc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [DataWidth-1:0]     s_tdata,   // point_x, point_y
  input  wire logic                     s_tlast,   // last_point
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [DataWidth-1:0]          m_tdata,   // vel_x, vel_y
  input  wire logic                     cfg_wen,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgWidth-1:0]      cfg_data
);

  logic [CfgWidth-1:0] body_radius;
  logic [CfgWidth-1:0] hold_distance;
  logic [ThrWidth-1:0] threshold;
  point_entry_t        entry;
  logic                entry_valid;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_radius   <= BodyRadiusReset;
      hold_distance <= HoldDistanceReset;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BODY_RADIUS:   body_radius   <= cfg_data;
        REG_HOLD_DISTANCE: hold_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign threshold = ThrWidth'(body_radius) + ThrWidth'(hold_distance);

  rvbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .entry       (entry),
    .entry_valid (entry_valid),
    .pop         (pop)
  );

  rvbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .threshold   (threshold),
    .entry       (entry),
    .entry_valid (entry_valid),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire

// ----- design/rvbc_checker.sv -----
`default_nettype none

module rvbc_checker
  import rvbc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 s_tlast,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [DataWidth-1:0] m_tdata
);

  logic [3:0] pending;
  logic       last_in;
  logic       res_out;

  assign last_in = s_tvalid && s_tready && s_tlast;
  assign res_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_in && !res_out) begin
      pending <= pending + 1'b1;
    end else if (res_out && !last_in) begin
      pending <= pending - 1'b1;
    end
  end

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> pending != 4'd0)
    else $error("result without an accepted end of scan");

  assert property (@(posedge clk) disable iff (rst) pending <= 4'd4)
    else $error("too many scans waiting for a result");

endmodule

bind repulsive_vector_box_center_unit rvbc_checker u_checker (.*);

`default_nettype wire

// ----- bench/repulsive_vector_box_center_unit_test.sv -----
`default_nettype none

module repulsive_vector_box_center_unit_test
  import rvbc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int SettleCycles = 100;
  localparam int PhaseItems = 190;
  localparam int NumPhases = 9;
  localparam int NumDirRows = 20;
  localparam longint CoordMax = (longint'(1) <<< (CoordWidth - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;

  typedef struct packed {
    logic signed [CoordWidth-1:0] vy;
    logic signed [CoordWidth-1:0] vx;
  } vel_cmd_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic                         last;
    logic                         typed;
    logic signed [CoordWidth-1:0] ex;
    logic signed [CoordWidth-1:0] ey;
  } scan_row_t;

  // typed rows assume the reset clearance of 128 + 128
  scan_row_t dir_rows [NumDirRows] = '{
    '{0, 0, 1, 1, 0, 0},
    '{32767, 32767, 1, 1, 0, 0},
    '{-32768, -32768, 1, 1, 0, 0},
    '{-32768, 32767, 1, 1, 0, 0},
    '{128, 0, 1, 1, -128, 0},
    '{0, -128, 1, 1, 0, 128},
    '{256, 0, 1, 1, 0, 0},
    '{257, 0, 1, 1, 0, 0},
    '{1, 0, 0, 0, 0, 0},
    '{-1, 1, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{200, -150, 0, 0, 0, 0},
    '{-32768, 0, 0, 0, 0, 0},
    '{-90, -90, 1, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0},
    '{-255, 0, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0},
    '{100, 100, 0, 0, 0, 0},
    '{-100, -100, 0, 0, 0, 0},
    '{0, 255, 1, 0, 0, 0}
  };

  int phase_radius [NumPhases] = '{128, 0, 16383, 16383, 0, 1, -1, -1, 128};
  int phase_hold   [NumPhases] = '{128, 0, 16383, 0, 16383, 0, -1, -1, 128};

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [DataWidth-1:0]     s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [DataWidth-1:0]     m_tdata;
  logic                     cfg_wen = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]      cfg_data = '0;

  logic [CfgWidth-1:0] radius_cfg = BodyRadiusReset;
  logic [CfgWidth-1:0] hold_cfg = HoldDistanceReset;
  longint box_x_low, box_x_high, box_y_low, box_y_high;
  bit near_seen;

  vel_cmd_t vel_cmd_q [$];
  int fail_count;
  int cycle_count;
  int rx_hold;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  repulsive_vector_box_center_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // push away from the coordinate, rounded half away from zero, saturated
  function automatic longint push_component(longint c, longint margin, longint distance);
    longint a;
    longint q;
    longint s;
    a = (c < 0) ? -c : c;
    q = (a * margin * 2 + distance) / (2 * distance);
    s = (c < 0) ? q : -q;
    if (s > CoordMax) s = CoordMax;
    else if (s < CoordMin) s = CoordMin;
    return s;
  endfunction

  task automatic fold_point(input logic signed [CoordWidth-1:0] px,
                            input logic signed [CoordWidth-1:0] py,
                            input bit last_pt, output bit emit, output vel_cmd_t cmd);
    longint x, y, distance, thr, vx, vy;
    x = px;
    y = py;
    emit = 1'b0;
    cmd = '0;
    if (x != 0 || y != 0) begin
      distance = floor_root(longint'(x * x + y * y));
      thr = longint'(radius_cfg) + longint'(hold_cfg);
      if (distance <= thr) begin
        vx = push_component(x, thr - distance, distance);
        vy = push_component(y, thr - distance, distance);
        if (!near_seen) begin
          box_x_low = vx;
          box_x_high = vx;
          box_y_low = vy;
          box_y_high = vy;
          near_seen = 1'b1;
        end else begin
          if (vx < box_x_low) box_x_low = vx;
          if (vx > box_x_high) box_x_high = vx;
          if (vy < box_y_low) box_y_low = vy;
          if (vy > box_y_high) box_y_high = vy;
        end
      end
    end
    if (last_pt) begin
      emit = 1'b1;
      if (near_seen) begin
        cmd.vx = CoordWidth'((box_x_low + box_x_high) >>> 1);
        cmd.vy = CoordWidth'((box_y_low + box_y_high) >>> 1);
      end
      box_x_low = 0;
      box_x_high = 0;
      box_y_low = 0;
      box_y_high = 0;
      near_seen = 1'b0;
    end
  endtask

  function automatic logic signed [CoordWidth-1:0] draw_coord(int reach);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return CoordWidth'($urandom);
    if (sel < 5) return '0;
    return CoordWidth'(int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  task automatic send_point(input logic signed [CoordWidth-1:0] px,
                            input logic signed [CoordWidth-1:0] py, input bit last_pt,
                            input bit typed, input vel_cmd_t typed_cmd, input bit no_gap);
    int gap;
    bit emit;
    vel_cmd_t cmd;
    gap = (no_gap || !tx_idle) ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DataWidth'({py, px});
    s_tlast <= last_pt;
    do @(posedge clk); while (!s_tready);
    fold_point(px, py, last_pt, emit, cmd);
    if (emit) vel_cmd_q.push_back(typed ? typed_cmd : cmd);
  endtask

  task automatic send_random_point(bit last_pt, bit no_gap);
    int reach;
    logic signed [CoordWidth-1:0] px, py;
    reach = int'(radius_cfg) + int'(hold_cfg);
    reach = reach + reach / 4 + 4;
    if (reach > 32767) reach = 32767;
    if ($urandom_range(0, 11) == 0) begin
      px = '0;
      py = '0;
    end else begin
      px = draw_coord(reach);
      py = draw_coord(reach);
    end
    send_point(px, py, last_pt, 1'b0, '0, no_gap);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input int val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgWidth'(val);
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_BODY_RADIUS: begin
        radius_cfg = CfgWidth'(val);
      end
      REG_HOLD_DISTANCE: begin
        hold_cfg = CfgWidth'(val);
      end
      default: begin
      end
    endcase
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (vel_cmd_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, int expv, int gotv);
    fail_count++;
    if (fail_count <= 10) $display("%0s: expected %0d, got %0d", what, expv, gotv);
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int gap;
    vel_cmd_t got;
    vel_cmd_t want;
    wait (!rst);
    forever begin
      if (rx_hold > 0) gap = rx_hold;
      else gap = rx_idle ? $urandom_range(0, 8) : 0;
      rx_hold = 0;
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata[2*CoordWidth-1:0];
      if (vel_cmd_q.size() == 0) begin
        flag_mismatch("velocity command with none pending, vel_x", 0, int'(got.vx));
      end else begin
        want = vel_cmd_q.pop_front();
        if (got.vx !== want.vx) flag_mismatch("vel_x", int'(want.vx), int'(got.vx));
        if (got.vy !== want.vy) flag_mismatch("vel_y", int'(want.vy), int'(got.vy));
      end
    end
  end

  initial begin
    int sent;
    int k;
    int len;
    int ph;
    int rad;
    int hld;
    vel_cmd_t typed_cmd;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < NumDirRows; k++) begin
      typed_cmd.vx = dir_rows[k].ex;
      typed_cmd.vy = dir_rows[k].ey;
      send_point(dir_rows[k].x, dir_rows[k].y, dir_rows[k].last, dir_rows[k].typed,
                 typed_cmd, 1'b0);
    end
    drain_results();

    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        rad = (phase_radius[ph] < 0) ? $urandom_range(0, 2000) : phase_radius[ph];
        hld = (phase_hold[ph] < 0) ? $urandom_range(0, 2000) : phase_hold[ph];
        write_reg(REG_BODY_RADIUS, rad);
        write_reg(REG_HOLD_DISTANCE, hld);
      end
      if (ph == 3) begin
        // stall the output long enough for the input queue to back up
        rx_hold = 400;
        for (k = 0; k < 16; k++) send_random_point(1'b1, 1'b1);
      end
      sent = 0;
      while (sent < PhaseItems) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
        for (k = 0; k < len; k++) begin
          send_random_point(k == len - 1, 1'b0);
          sent++;
        end
      end
      drain_results();
    end

    if (fail_count == 0 && vel_cmd_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
